/* rtl/core/qves_pkg.sv */
// Shared widths, defaults and mapping selector codes for the entry search block.
package qves_pkg;

    localparam int W_VAL   = 16;
    localparam int W_ENTRY = 8;
    localparam int W_SEL   = 5;

    localparam int ENTRY_MAX_DEF = 255;

    // mapping selector codes; anything above MAP_16B_FASTEST acts as identity
    localparam logic [W_SEL-1:0] MAP_IDENT       = 5'd0;
    localparam logic [W_SEL-1:0] MAP_8B_FAST1    = 5'd1;
    localparam logic [W_SEL-1:0] MAP_8B_FAST2    = 5'd2;
    localparam logic [W_SEL-1:0] MAP_8B_FAST3    = 5'd3;
    localparam logic [W_SEL-1:0] MAP_8B_FAST4    = 5'd4;
    localparam logic [W_SEL-1:0] MAP_8B_FAST5    = 5'd5;
    localparam logic [W_SEL-1:0] MAP_8B_FAST6    = 5'd6;
    localparam logic [W_SEL-1:0] MAP_8B_FAST7    = 5'd7;
    localparam logic [W_SEL-1:0] MAP_8B_FASTEST  = 5'd8;
    localparam logic [W_SEL-1:0] MAP_10B         = 5'd9;
    localparam logic [W_SEL-1:0] MAP_10B_FAST1   = 5'd10;
    localparam logic [W_SEL-1:0] MAP_10B_FAST2   = 5'd11;
    localparam logic [W_SEL-1:0] MAP_10B_FAST3   = 5'd12;
    localparam logic [W_SEL-1:0] MAP_10B_FAST4   = 5'd13;
    localparam logic [W_SEL-1:0] MAP_10B_FASTEST = 5'd14;
    localparam logic [W_SEL-1:0] MAP_12B         = 5'd15;
    localparam logic [W_SEL-1:0] MAP_12B_FASTEST = 5'd16;
    localparam logic [W_SEL-1:0] MAP_16B         = 5'd17;
    localparam logic [W_SEL-1:0] MAP_16B_FASTEST = 5'd18;

endpackage

/* rtl/core/quant_value_to_entry_search.sv */
// Top level: quantizer value to entry index search with one shared mapping unit.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries a target value and a
//   round-up flag; the output channel (o_out_valid / i_out_ready) returns the
//   chosen entry index, 1 to P_ENTRY_MAX. Exactly one result per item.
//   i_cfg_we with i_cfg_wdata writes the mapping selector; write it only
//   while the block is idle. Codes above 18 behave as identity.
// Sequence
//   One mapping evaluation per cycle: the end values are fetched first,
//   then come the binary search probes (at most eight for 255 entries),
//   then the bracket settles, then the walk-down steps over equal mapped
//   values, and last the output register is loaded. The next item is taken
//   only once the sequencer is back in idle.
// Reset and stalls
//   Synchronous active-low reset returns the sequencer to idle, drops the
//   output valid and sets the selector to identity. A finished result sits
//   in the output register; the next item is accepted meanwhile, and its
//   result waits in the walk-down state until the output register frees.
module quant_value_to_entry_search #(
    parameter int P_ENTRY_MAX = qves_pkg::ENTRY_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [qves_pkg::W_SEL-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [qves_pkg::W_VAL-1:0]   i_target_value,
    input  logic                         i_round_up,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [qves_pkg::W_ENTRY-1:0] o_entry_index
);
    import qves_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
    localparam logic [2:0] S_LO   = 3'd1;  // fetch value of entry 1
    localparam logic [2:0] S_HI   = 3'd2;  // fetch value of the last entry
    localparam logic [2:0] S_SRCH = 3'd3;  // binary search probes
    localparam logic [2:0] S_WALK = 3'd4;  // step down over equal values

    localparam logic [W_ENTRY-1:0] ENTRY_LAST = W_ENTRY'(P_ENTRY_MAX);
    localparam logic [W_ENTRY-1:0] ENTRY_ONE  = W_ENTRY'(1);

    logic [2:0]         r_state, n_state;
    logic [W_SEL-1:0]   r_sel;
    logic [W_VAL-1:0]   r_q;
    logic               r_up;
    logic [W_ENTRY-1:0] r_lo_e, n_lo_e, r_hi_e, n_hi_e, r_pick_e, n_pick_e;
    logic [W_VAL-1:0]   r_lo_v, n_lo_v, r_hi_v, n_hi_v, r_pick_v, n_pick_v;
    logic               r_out_valid, n_out_valid;
    logic [W_ENTRY-1:0] r_out_e, n_out_e;

    logic [W_ENTRY-1:0] map_e;
    logic [W_VAL-1:0]   map_v;
    logic [W_ENTRY:0]   mid_sum;
    logic [W_ENTRY-1:0] mid_e;
    logic               in_acc, out_free;

    qves_mapper u_mapper (
        .i_sel   (r_sel),
        .i_entry (map_e),
        .o_value (map_v)
    );

    assign mid_sum  = {1'b0, r_lo_e} + {1'b0, r_hi_e};
    assign mid_e    = mid_sum[W_ENTRY:1];
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // address of the shared mapping unit
    always_comb begin
        case (r_state)
            S_LO:    map_e = ENTRY_ONE;
            S_HI:    map_e = ENTRY_LAST;
            S_WALK:  map_e = r_pick_e - ENTRY_ONE;
            default: map_e = mid_e;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_lo_e      = r_lo_e;
        n_hi_e      = r_hi_e;
        n_lo_v      = r_lo_v;
        n_hi_v      = r_hi_v;
        n_pick_e    = r_pick_e;
        n_pick_v    = r_pick_v;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_e     = r_out_e;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LO;
                end
            end
            S_LO: begin
                n_lo_e  = ENTRY_ONE;
                n_lo_v  = map_v;
                n_state = S_HI;
            end
            S_HI: begin
                n_hi_e   = ENTRY_LAST;
                n_hi_v   = map_v;
                n_pick_e = r_lo_e;
                n_pick_v = r_lo_v;
                n_state  = S_SRCH;
            end
            S_SRCH: begin
                if (r_q > r_lo_v && r_q < r_hi_v && mid_e != r_lo_e) begin
                    // probe the midpoint
                    n_pick_e = mid_e;
                    n_pick_v = map_v;
                    if (r_q < map_v) begin
                        n_hi_e = mid_e;
                        n_hi_v = map_v;
                    end else begin
                        n_lo_e = mid_e;
                        n_lo_v = map_v;
                    end
                end else begin
                    // bracket settled: choose the entry
                    n_state = S_WALK;
                    if (r_q <= r_lo_v) begin
                        n_pick_e = r_lo_e;
                        n_pick_v = r_lo_v;
                    end else if (r_q >= r_hi_v || r_up) begin
                        n_pick_e = r_hi_e;
                        n_pick_v = r_hi_v;
                    end else begin
                        // strictly between, round down: keep last probed value
                        n_pick_e = r_lo_e;
                    end
                end
            end
            S_WALK: begin
                if (r_pick_e > ENTRY_ONE && map_v == r_pick_v) begin
                    n_pick_e = r_pick_e - ENTRY_ONE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_e     = r_pick_e;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= MAP_IDENT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_sel <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q  <= i_target_value;
            r_up <= i_round_up;
        end
        r_lo_e   <= n_lo_e;
        r_hi_e   <= n_hi_e;
        r_lo_v   <= n_lo_v;
        r_hi_v   <= n_hi_v;
        r_pick_e <= n_pick_e;
        r_pick_v <= n_pick_v;
        r_out_e  <= n_out_e;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_entry_index = r_out_e;

    // checks
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_index >= ENTRY_ONE && o_entry_index <= ENTRY_LAST))
        else $error("entry index out of range");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_LO))
        else $error("accepted item did not start the search");

    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_lo_e < r_hi_e))
        else $error("search bracket collapsed");

    a_walk_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_pick_e >= ENTRY_ONE))
        else $error("walk-down passed entry 1");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_entry_index)))
        else $error("stalled result changed");

endmodule

/* rtl/core/qves_mapper.sv */
// Shared entry-to-value mapping unit: one evaluation of the selected mapping.
module qves_mapper (
    input  logic [qves_pkg::W_SEL-1:0]   i_sel,
    input  logic [qves_pkg::W_ENTRY-1:0] i_entry,
    output logic [qves_pkg::W_VAL-1:0]   o_value
);
    import qves_pkg::*;

    logic [W_VAL-1:0] e;
    logic [W_VAL-1:0] v;

    assign e = {{(W_VAL-W_ENTRY){1'b0}}, i_entry};

    always_comb begin
        v = e;
        case (i_sel)
            MAP_8B_FAST1: begin
                if (e <= 16)       v = e;
                else if (e < 128)  v = 16'(2*e - 16);
                else               v = 16'd255;
            end
            MAP_8B_FAST2: begin
                if (e <= 16)       v = e;
                else if (e <= 64)  v = 16'(2*e - 16);
                else if (e <= 99)  v = 16'(4*e - 144);
                else               v = 16'd255;
            end
            MAP_8B_FAST3: begin
                if (e <= 16)       v = 16'(2*e);
                else if (e <= 32)  v = 16'(4*e - 32);
                else if (e < 52)   v = 16'(8*e - 160);
                else               v = 16'd255;
            end
            MAP_8B_FAST4: begin
                if (e <= 8)        v = 16'(2*e);
                else if (e <= 16)  v = 16'(4*e - 16);
                else if (e <= 32)  v = 16'(8*e - 80);
                else if (e < 37)   v = 16'(16*e - 336);
                else               v = 16'd255;
            end
            MAP_8B_FAST5: begin
                if (e <= 8)        v = 16'(2*e);
                else if (e <= 14)  v = 16'(4*e - 16);
                else if (e <= 20)  v = 16'(8*e - 72);
                else if (e <= 24)  v = 16'(16*e - 232);
                else if (e < 28)   v = 16'(32*e - 616);
                else               v = 16'd255;
            end
            MAP_8B_FAST6: begin
                if (e <= 8)        v = 16'(2*e);
                else if (e <= 14)  v = 16'(4*e - 16);
                else if (e == 15)  v = 16'd64;
                else if (e == 16)  v = 16'd96;
                else if (e == 17)  v = 16'd128;
                else if (e == 18)  v = 16'd176;
                else               v = 16'd255;
            end
            MAP_8B_FAST7: begin
                if (e <= 5)        v = 16'(2*e);
                else if (e <= 8)   v = 16'(4*e - 10);
                else if (e <= 11)  v = 16'(8*e - 42);
                else if (e == 12)  v = 16'd96;
                else if (e == 13)  v = 16'd128;
                else               v = 16'd255;
            end
            MAP_8B_FASTEST: begin
                if (e <= 1)        v = 16'd2;
                else if (e <= 5)   v = 16'(4*e - 2);
                else if (e == 6)   v = 16'd32;
                else if (e == 7)   v = 16'd128;
                else               v = 16'd255;
            end
            MAP_10B: begin
                if (e <= 16)       v = e;
                else if (e <= 64)  v = 16'(2*e);
                else if (e <= 128) v = 16'(3*e);
                else if (e < 255)  v = 16'(4*e);
                else               v = 16'd1023;
            end
            MAP_10B_FAST1: begin
                if (e < 8)         v = e;
                else if (e <= 16)  v = 16'(2*e);
                else if (e <= 64)  v = 16'(3*e);
                else if (e <= 128) v = 16'(4*e);
                else if (e <= 204) v = 16'(5*e);
                else               v = 16'd1023;
            end
            MAP_10B_FAST2: begin
                if (e <= 2)        v = e;
                else if (e <= 4)   v = 16'(2*e);
                else if (e <= 8)   v = 16'(3*e);
                else if (e <= 16)  v = 16'(4*e);
                else if (e <= 64)  v = 16'(5*e);
                else if (e <= 128) v = 16'(6*e);
                else if (e <= 146) v = 16'(7*e);
                else               v = 16'd1023;
            end
            MAP_10B_FAST3: begin
                if (e <= 4)        v = 16'(2*e);
                else if (e <= 8)   v = 16'(4*e);
                else if (e <= 16)  v = 16'(8*e);
                else if (e < 64)   v = 16'(16*e);
                else               v = 16'd1023;
            end
            MAP_10B_FAST4: begin
                if (e <= 4)        v = 16'(4*e);
                else if (e <= 8)   v = 16'(8*e);
                else if (e <= 16)  v = 16'(16*e);
                else if (e < 32)   v = 16'(32*e);
                else               v = 16'd1023;
            end
            MAP_10B_FASTEST: begin
                if (e >= 1 && e < 10) v = 16'd1 << (e - 16'd1);
                else                  v = 16'd1023;
            end
            MAP_12B: begin
                if (e <= 8)        v = e;
                else if (e <= 16)  v = 16'(4*e);
                else if (e <= 32)  v = 16'(6*e);
                else if (e <= 64)  v = 16'(4*e);
                else if (e <= 128) v = 16'(8*e);
                else if (e < 255)  v = 16'(16*e);
                else               v = 16'd4095;
            end
            MAP_12B_FASTEST: begin
                if (e >= 1 && e < 12) v = 16'd1 << (e - 16'd1);
                else                  v = 16'd4095;
            end
            MAP_16B: begin
                if (e <= 1)        v = e;
                else if (e <= 2)   v = 16'(2*e);
                else if (e <= 4)   v = 16'(4*e);
                else if (e <= 8)   v = 16'(8*e);
                else if (e <= 16)  v = 16'(16*e);
                else if (e <= 32)  v = 16'(32*e);
                else if (e <= 64)  v = 16'(64*e);
                else if (e <= 128) v = 16'(128*e);
                else if (e < 255)  v = 16'(256*e);
                else               v = 16'd65535;
            end
            MAP_16B_FASTEST: begin
                if (e >= 1 && e < 16) v = 16'd1 << (e - 16'd1);
                else                  v = 16'd65535;
            end
            default: begin
                v = e;
            end
        endcase
    end

    assign o_value = v;

endmodule
